### src/blecw_pkg.sv
// Shared types, constants and bit functions for the BLE CRC-24 and whitening encoder.
// No dependencies; every other file of the encoder imports this package.
`default_nettype none

package blecw_pkg;

    // CRC-24 polynomial taps, LSB-first update.
    localparam logic [23:0] CRC_TAPS      = 24'h00065B;
    localparam logic [23:0] CRC_INIT_RST  = 24'h555555;
    // Whitening LFSR feedback and seed marker bit.
    localparam logic [7:0]  WHT_FEEDBACK  = 8'h11;
    localparam logic [7:0]  WHT_SEED_BIT  = 8'h02;
    // Depth of the queue between the front and back parts.
    localparam int          QUEUE_DEPTH   = 4;

    // Input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [5:0] channel;
        logic       last_byte;
    } t_in_item;

    // Output beat.
    typedef struct packed {
        logic [7:0] coded_byte;
        logic       is_crc;
        logic       end_of_packet;
    } t_out_item;

    // Command passed from the front part to the back part through the queue.
    typedef struct packed {
        logic [7:0]  coded;
        logic        last;
        logic [23:0] crc;
        logic [7:0]  wht;
    } t_cmd;

    // Result of whitening one byte.
    typedef struct packed {
        logic [7:0] state;
        logic [7:0] data;
    } t_wht_res;

    // Reverse the bit order of a byte.
    function automatic logic [7:0] rev8(input logic [7:0] a);
        logic [7:0] v;
        for (int i = 0; i < 8; i++) begin
            v[7 - i] = a[i];
        end
        return v;
    endfunction

    // Run the CRC over one byte, LSB first.
    function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] d);
        logic [23:0] c;
        logic        top;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            top = c[23];
            c   = {c[22:0], 1'b0};
            if (top != d[i]) begin
                c = c ^ CRC_TAPS;
            end
        end
        return c;
    endfunction

    // Whiten one byte, LSB first, and return the advanced LFSR state.
    function automatic t_wht_res whiten_byte(input logic [7:0] w, input logic [7:0] d);
        t_wht_res r;
        logic [7:0] s;
        logic [7:0] x;
        s = w;
        x = d;
        for (int i = 0; i < 8; i++) begin
            if (s[7]) begin
                s    = s ^ WHT_FEEDBACK;
                x[i] = ~x[i];
            end
            s = {s[6:0], 1'b0};
        end
        r.state = s;
        r.data  = x;
        return r;
    endfunction

endpackage

`default_nettype wire

### src/ble_packet_crc_whiten_encoder_core.sv
// Top level of the BLE CRC-24 and whitening encoder: config register, front, queue, back.
// Depends on blecw_pkg, blecw_front, blecw_queue and blecw_back.
//
//   Channel   Handshake              Payload
//   input     push / full            i_in (t_in_item)
//   result    pop / empty            o_out (t_out_item)
//   config    i_cfg_valid/o_cfg_ready i_cfg_data (CRC initial value)
//
// A data byte goes through CRC and whitening in the cycle it is accepted and is queued.
// Its beat passes through the queue, the back part's held command and its output register;
// a last byte yields three more CRC beats, one per cycle while popped, from that register.
// Sustained rate is one input beat per cycle, limited by the back part at one output beat
// per cycle while popped. Reset is synchronous, active low, and clears the queue and
// packet state. Full rises when the queue fills; a stalled pop holds the output register.
`default_nettype none

module ble_packet_crc_whiten_encoder_core #(
    parameter int QUEUE_DEPTH = blecw_pkg::QUEUE_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    input  wire blecw_pkg::t_in_item i_in,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output blecw_pkg::t_out_item     o_out,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [23:0]         i_cfg_data
);
    import blecw_pkg::*;

    logic        r_crc_init;
    logic [23:0] r_crc_init_val;
    logic        accept;
    t_cmd        front_cmd;
    t_cmd        queue_cmd;
    logic        queue_empty;
    logic        queue_pop;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    // CRC initial value register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_init     <= 1'b0;
            r_crc_init_val <= CRC_INIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_crc_init     <= 1'b1;
            r_crc_init_val <= i_cfg_data;
        end
    end

    blecw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in),
        .i_crc_init (r_crc_init ? r_crc_init_val : CRC_INIT_RST),
        .o_cmd      (front_cmd)
    );

    blecw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept),
        .i_wr_data (front_cmd),
        .o_full    (full),
        .i_rd_en   (queue_pop),
        .o_rd_data (queue_cmd),
        .o_empty   (queue_empty)
    );

    blecw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_empty (queue_empty),
        .o_cmd_pop   (queue_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out)
    );

endmodule

`default_nettype wire

### src/blecw_queue.sv
// Small first-in first-out queue of commands between the front and back parts.
// Depends on blecw_pkg for the command type.
`default_nettype none

module blecw_queue #(
    parameter int DEPTH = blecw_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr_en,
    input  wire blecw_pkg::t_cmd i_wr_data,
    output logic                o_full,
    input  wire logic           i_rd_en,
    output blecw_pkg::t_cmd     o_rd_data,
    output logic                o_empty
);
    import blecw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              wr_go;
    logic              rd_go;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_go     = i_wr_en && !o_full;
    assign rd_go     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_go) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_go) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_go && !rd_go) begin
                r_count <= r_count + 1'b1;
            end else if (rd_go && !wr_go) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### src/blecw_front.sv
// Front part: takes input beats, runs CRC-24 and whitening per byte, and queues commands.
// Depends on blecw_pkg for the beat types and the bit functions.
`default_nettype none

module blecw_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire blecw_pkg::t_in_item i_item,
    input  wire logic [23:0]       i_crc_init,
    output blecw_pkg::t_cmd        o_cmd
);
    import blecw_pkg::*;

    logic        r_open;
    logic [23:0] r_crc;
    logic [7:0]  r_wht;
    logic [23:0] crc_base;
    logic [7:0]  wht_base;
    logic [23:0] crc_new;
    t_wht_res    wres;

    // Start of packet reloads the CRC and seeds the LFSR from the channel.
    always_comb begin
        crc_base = r_open ? r_crc : i_crc_init;
        wht_base = r_open ? r_wht : (rev8({2'b00, i_item.channel}) | WHT_SEED_BIT);
        crc_new  = crc_byte(crc_base, i_item.data_byte);
        wres     = whiten_byte(wht_base, i_item.data_byte);

        o_cmd.coded = rev8(wres.data);
        o_cmd.last  = i_item.last_byte;
        o_cmd.crc   = crc_new;
        o_cmd.wht   = wres.state;
    end

    // Running packet state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (i_accept) begin
            r_open <= !i_item.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_crc <= crc_new;
            r_wht <= wres.state;
        end
    end

endmodule

`default_nettype wire

### src/blecw_back.sv
// Back part: turns queued commands into output beats, appending the three CRC bytes.
// Depends on blecw_pkg for the command and beat types and the bit functions.
`default_nettype none

module blecw_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire blecw_pkg::t_cmd i_cmd,
    input  wire logic            i_cmd_empty,
    output logic                 o_cmd_pop,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output blecw_pkg::t_out_item o_item
);
    import blecw_pkg::*;

    localparam logic [1:0] PH_DATA    = 2'd0;
    localparam logic [1:0] PH_CRC_HI  = 2'd1;
    localparam logic [1:0] PH_CRC_MID = 2'd2;
    localparam logic [1:0] PH_CRC_LO  = 2'd3;

    logic        r_busy;
    logic [1:0]  r_phase;
    t_cmd        r_cmd;
    logic [7:0]  r_wht;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        can_emit;
    logic        emit;
    logic        done;
    logic        load;
    logic [7:0]  crc_sel;
    t_wht_res    wres;
    t_out_item   res;

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    // Result for the current phase of the held command.
    always_comb begin
        unique case (r_phase)
            PH_CRC_HI:  crc_sel = r_cmd.crc[23:16];
            PH_CRC_MID: crc_sel = r_cmd.crc[15:8];
            PH_CRC_LO:  crc_sel = r_cmd.crc[7:0];
            default:    crc_sel = r_cmd.crc[7:0];
        endcase
        wres = whiten_byte(r_wht, rev8(crc_sel));

        if (r_phase == PH_DATA) begin
            res.coded_byte    = r_cmd.coded;
            res.is_crc        = 1'b0;
            res.end_of_packet = 1'b0;
        end else begin
            res.coded_byte    = rev8(wres.data);
            res.is_crc        = 1'b1;
            res.end_of_packet = (r_phase == PH_CRC_LO);
        end

        can_emit  = !r_out_valid || i_pop;
        emit      = r_busy && can_emit;
        done      = ((r_phase == PH_DATA) && !r_cmd.last) || (r_phase == PH_CRC_LO);
        load      = !i_cmd_empty && (!r_busy || (emit && done));
        o_cmd_pop = load;
    end

    // Held command, phase and whitening state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_DATA;
        end else if (load) begin
            r_busy  <= 1'b1;
            r_phase <= PH_DATA;
        end else if (emit && done) begin
            r_busy  <= 1'b0;
        end else if (emit) begin
            r_phase <= r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
            r_wht <= i_cmd.wht;
        end else if (emit && (r_phase != PH_DATA)) begin
            r_wht <= wres.state;
        end
    end

    // Output register; a beat waits here until popped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

### test/ble_packet_crc_whiten_encoder_check.sv
// Checker for the BLE CRC-24 and whitening encoder: watches the input, result and config beats.
// Predicts every result beat on its own and compares it; depends on blecw_pkg for types.
`default_nettype none

module ble_packet_crc_whiten_encoder_check (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic                 i_full,
    input  wire blecw_pkg::t_in_item  i_in,
    input  wire logic                 i_pop,
    input  wire logic                 i_empty,
    input  wire blecw_pkg::t_out_item i_out,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [23:0]          i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import blecw_pkg::*;

    localparam int MAX_PRINTED = 100;

    // Mirror of the encoder state.
    logic [23:0] crc_start  = CRC_INIT_RST;
    logic [23:0] crc_state  = CRC_INIT_RST;
    logic [7:0]  wht_state  = 8'h00;
    logic        in_packet  = 1'b0;

    t_out_item   coded_q[$];
    int          fail_count = 0;
    int          beat_index = 0;

    assign o_fail_count = fail_count;

    function automatic logic [7:0] mirror_byte(input logic [7:0] a);
        logic [7:0] v;
        for (int i = 0; i < 8; i++) begin
            v[i] = a[7 - i];
        end
        return v;
    endfunction

    // Advance the CRC over one raw byte, LSB first.
    function automatic void crc_absorb(input logic [7:0] d);
        logic msb;
        for (int i = 0; i < 8; i++) begin
            msb       = crc_state[23];
            crc_state = {crc_state[22:0], 1'b0};
            if (msb != d[i]) begin
                crc_state = crc_state ^ CRC_TAPS;
            end
        end
    endfunction

    // XOR one byte with the whitening sequence, stepping the LFSR once per bit.
    function automatic logic [7:0] whiten_next(input logic [7:0] d);
        logic [7:0] x;
        x = d;
        for (int i = 0; i < 8; i++) begin
            if (wht_state[7]) begin
                wht_state = wht_state ^ WHT_FEEDBACK;
                x[i]      = ~x[i];
            end
            wht_state = {wht_state[6:0], 1'b0};
        end
        return x;
    endfunction

    // Work out the result beats caused by one accepted input beat.
    function automatic void predict_coded(input t_in_item it);
        t_out_item  r;
        logic [7:0] crc_part;
        if (!in_packet) begin
            crc_state = crc_start;
            wht_state = mirror_byte({2'b00, it.channel}) | WHT_SEED_BIT;
        end
        crc_absorb(it.data_byte);
        r.coded_byte    = mirror_byte(whiten_next(it.data_byte));
        r.is_crc        = 1'b0;
        r.end_of_packet = 1'b0;
        coded_q.push_back(r);
        if (it.last_byte) begin
            // CRC bytes go out high byte first.
            for (int k = 0; k < 3; k++) begin
                crc_part        = crc_state[23 - 8 * k -: 8];
                r.coded_byte    = mirror_byte(whiten_next(mirror_byte(crc_part)));
                r.is_crc        = 1'b1;
                r.end_of_packet = (k == 2);
                coded_q.push_back(r);
            end
            in_packet = 1'b0;
        end else begin
            in_packet = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    // Compare one accepted result beat with the oldest prediction.
    task automatic check_coded(input t_out_item got);
        t_out_item want;
        if (coded_q.size() == 0) begin
            report_mismatch($sformatf("beat %0d: unexpected result %h/%b/%b", beat_index,
                            got.coded_byte, got.is_crc, got.end_of_packet));
        end else begin
            want = coded_q.pop_front();
            if (got.coded_byte !== want.coded_byte || got.is_crc !== want.is_crc ||
                got.end_of_packet !== want.end_of_packet) begin
                report_mismatch($sformatf("beat %0d: got %h/%b/%b, expected %h/%b/%b",
                                beat_index, got.coded_byte, got.is_crc, got.end_of_packet,
                                want.coded_byte, want.is_crc, want.end_of_packet));
            end
        end
        beat_index++;
    endtask

    // Sample all channels at the clock edge; results leave before new inputs are predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            crc_start = CRC_INIT_RST;
            crc_state = CRC_INIT_RST;
            wht_state = 8'h00;
            in_packet = 1'b0;
            coded_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                check_coded(i_out);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                crc_start = i_cfg_data;
            end
            if (i_push && !i_full) begin
                predict_coded(i_in);
            end
        end
        o_pending <= coded_q.size();
    end

endmodule

`default_nettype wire

### test/ble_packet_crc_whiten_encoder_core_test.sv
// Testbench top for the BLE CRC-24 and whitening encoder: clock, reset, stimulus and verdict.
// Depends on blecw_pkg, the encoder core and ble_packet_crc_whiten_encoder_check.
`default_nettype none

module ble_packet_crc_whiten_encoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import blecw_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 95;
    localparam int SETTLE_TICKS = 8;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    t_in_item    i_in        = '0;
    logic        full;
    logic        pop         = 1'b0;
    logic        empty;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data  = 24'h0;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          hold_mode   = 0;
    int          hold_left   = 0;

    ble_packet_crc_whiten_encoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in        (i_in),
        .full        (full),
        .pop         (pop),
        .empty       (empty),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    ble_packet_crc_whiten_encoder_check i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in         (i_in),
        .i_pop        (pop),
        .i_empty      (empty),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: pop follows a randomly chosen mode: always, random, rare or never.
    always @(posedge i_clk) begin
        if (hold_left == 0) begin
            hold_mode <= $urandom_range(0, 3);
            hold_left <= $urandom_range(16, 64);
        end else begin
            hold_left <= hold_left - 1;
        end
        case (hold_mode)
            0: begin
                pop <= 1'b1;
            end
            1: begin
                pop <= 1'($urandom_range(0, 1));
            end
            2: begin
                pop <= ($urandom_range(0, 4) == 0);
            end
            default: begin
                pop <= 1'b0;
            end
        endcase
    end

    // Offer one input beat and hold it until accepted; gaps fall between bursts.
    task automatic send_beat(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        push <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (full);
    endtask

    // Stop sending and wait until every predicted beat has been popped.
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_crc_start(input logic [23:0] value);
        drain_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_beat(input logic [7:0] d, input logic [5:0] ch,
                                           input logic last);
        t_in_item it;
        it.data_byte = d;
        it.channel   = ch;
        it.last_byte = last;
        return it;
    endfunction

    // One packet of random bytes; later bytes carry random channels that must be ignored.
    // With hold_mid set, the sender stops after the first byte until all results are out.
    task automatic send_packet(input int len, input logic [5:0] ch, input logic hold_mid);
        logic [5:0] beat_ch;
        for (int i = 0; i < len; i++) begin
            beat_ch = (i == 0) ? ch : 6'($urandom_range(0, 63));
            send_beat(make_beat(8'($urandom), beat_ch, i == len - 1));
            if (hold_mid && i == 0) begin
                drain_results();
            end
        end
    endtask

    // A run of random packets, mostly short, with most channels in range.
    task automatic run_packets(input int count, input logic with_hold);
        int         sent;
        int         len;
        logic [5:0] ch;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            if (len > count - sent) begin
                len = count - sent;
            end
            ch = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(40, 63))
                                             : 6'($urandom_range(0, 39));
            send_packet(len, ch, with_hold && sent >= count / 2 && len > 1);
            if (with_hold && sent >= count / 2 && len > 1) begin
                with_hold = 1'b0;
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats under the reset CRC start value.
        send_beat(make_beat(8'h00, 6'd0, 1'b1));
        send_beat(make_beat(8'hFF, 6'd63, 1'b1));
        send_beat(make_beat(8'hA5, 6'd40, 1'b1));
        send_beat(make_beat(8'hFF, 6'd39, 1'b0));
        send_beat(make_beat(8'h00, 6'd5, 1'b0));
        send_beat(make_beat(8'h55, 6'd0, 1'b0));
        send_beat(make_beat(8'hAA, 6'd63, 1'b1));
        send_beat(make_beat(8'h01, 6'd37, 1'b0));
        send_beat(make_beat(8'h80, 6'd63, 1'b1));
        send_beat(make_beat(8'h5A, 6'd38, 1'b1));

        // Random phases, each under its own CRC start value.
        write_crc_start(24'h000000);
        run_packets(PHASE_ITEMS, 1'b0);
        write_crc_start(24'hFFFFFF);
        run_packets(PHASE_ITEMS, 1'b1);
        write_crc_start(24'($urandom));
        run_packets(PHASE_ITEMS, 1'b0);
        write_crc_start(CRC_INIT_RST);
        run_packets(PHASE_ITEMS, 1'b0);

        drain_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
